// ===== hw/rtl/xenu_pkg.sv =====
// Shared constants, widths and arctangent table for the ENU rotation.
`timescale 1ns / 1ps
`default_nettype none
package xenu_pkg;

  localparam int CW = 34;  // CORDIC x/y and trig word, Q2.30 with headroom
  localparam int ZW = 35;  // CORDIC angle word, Q2.30 with headroom

  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

  // atan(2^-i) * 2^30, truncated
  function automatic logic signed [ZW-1:0] atan_q30(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = 35'sd843314856;
      1:  v = 35'sd497837829;
      2:  v = 35'sd263043836;
      3:  v = 35'sd133525158;
      4:  v = 35'sd67021686;
      5:  v = 35'sd33543515;
      6:  v = 35'sd16775850;
      7:  v = 35'sd8388437;
      8:  v = 35'sd4194282;
      9:  v = 35'sd2097149;
      10: v = 35'sd1048575;
      11: v = 35'sd524287;
      12: v = 35'sd262143;
      13: v = 35'sd131071;
      14: v = 35'sd65535;
      15: v = 35'sd32767;
      16: v = 35'sd16383;
      17: v = 35'sd8191;
      18: v = 35'sd4095;
      19: v = 35'sd2047;
      20: v = 35'sd1023;
      21: v = 35'sd511;
      22: v = 35'sd255;
      23: v = 35'sd127;
      24: v = 35'sd63;
      25: v = 35'sd31;
      26: v = 35'sd15;
      27: v = 35'sd7;
      28: v = 35'sd3;
      29: v = 35'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/xenu_sincos.sv =====
// Pipelined rotation-mode CORDIC: sine and cosine of a Q3.28 angle.
`timescale 1ns / 1ps
`default_nettype none
module xenu_sincos #(
  parameter int STAGES = 24
) (
  input  wire logic                           clk,
  input  wire logic signed [30:0]             ang,
  output logic signed [xenu_pkg::CW-1:0]      cos_out,
  output logic signed [xenu_pkg::CW-1:0]      sin_out
);
  import xenu_pkg::*;

  localparam int NSTG = (STAGES > 32) ? 32 : STAGES;

  logic signed [CW-1:0] x_r [0:NSTG];
  logic signed [CW-1:0] y_r [0:NSTG];
  logic signed [ZW-1:0] z_r [0:NSTG];
  logic                 neg_r [0:NSTG];

  logic signed [ZW-1:0] z_in;
  logic signed [ZW-1:0] z_fold_nxt;
  logic                 neg_nxt;

  assign z_in = {{2{ang[30]}}, ang, 2'b00};

  // fold into [-pi/2, pi/2]; results get negated at the end
  always_comb begin
    z_fold_nxt = z_in;
    neg_nxt    = 1'b0;
    if (z_in > HALF_PI_Q30) begin
      z_fold_nxt = z_in - PI_Q30;
      neg_nxt    = 1'b1;
    end else if (z_in < -HALF_PI_Q30) begin
      z_fold_nxt = z_in + PI_Q30;
      neg_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]   <= GAIN_Q30;
    y_r[0]   <= '0;
    z_r[0]   <= z_fold_nxt;
    neg_r[0] <= neg_nxt;
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    always_ff @(posedge clk) begin
      neg_r[i+1] <= neg_r[i];
      if (!z_r[i][ZW-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - atan_q30(i);
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + atan_q30(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    cos_out <= neg_r[NSTG] ? -x_r[NSTG] : x_r[NSTG];
    sin_out <= neg_r[NSTG] ? -y_r[NSTG] : y_r[NSTG];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/xyz_to_east_north_up_rotation.sv =====
// Top level: rotates a Cartesian vector into east, north, up components.
//
//  channel | ports                                      | handshake
//  --------+--------------------------------------------+----------------------
//  input   | in_vec_x/y/z, in_lon_angle, in_lat_angle   | start & !busy accepts
//  result  | out_east_out/north_out/up_out, out_saturated | out_valid, one cycle
//
// One item per clock; busy is never raised. Pipeline steps in order
// (TRIG_STAGES capped at 32): fold, one CORDIC stage per iteration, sign fix,
// trig products, component products, sum/round, clamp.
// Reset clears only the valid line; the receiver cannot stall the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module xyz_to_east_north_up_rotation #(
  parameter int TRIG_STAGES = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_vec_x,
  input  wire logic signed [31:0] in_vec_y,
  input  wire logic signed [31:0] in_vec_z,
  input  wire logic signed [30:0] in_lon_angle,
  input  wire logic signed [29:0] in_lat_angle,
  output logic                    out_valid,
  output logic signed [31:0]      out_east_out,
  output logic signed [31:0]      out_north_out,
  output logic signed [31:0]      out_up_out,
  output logic                    out_saturated
);
  import xenu_pkg::*;

  localparam int NSTG   = (TRIG_STAGES > 32) ? 32 : TRIG_STAGES;
  localparam int LAT_SC = NSTG + 2;
  localparam int TOTAL  = LAT_SC + 4;
  localparam int PW     = 52;  // component product after >>14
  localparam int SW     = 38;  // rounded sum before clamp

  localparam logic signed [SW-1:0] MAX32 = 38'sd2147483647;
  localparam logic signed [SW-1:0] MIN32 = -38'sd2147483648;

  logic signed [CW-1:0] clon, slon, clat, slat;

  assign busy = 1'b0;

  xenu_sincos #(.STAGES(NSTG)) u_lon (
    .clk(clk), .ang(in_lon_angle), .cos_out(clon), .sin_out(slon)
  );
  xenu_sincos #(.STAGES(NSTG)) u_lat (
    .clk(clk), .ang({in_lat_angle[29], in_lat_angle}), .cos_out(clat), .sin_out(slat)
  );

  // valid line and vector delay
  logic [TOTAL-1:0]  vld_r;
  logic signed [31:0] vx_r [0:LAT_SC];
  logic signed [31:0] vy_r [0:LAT_SC];
  logic signed [31:0] vz_r [0:LAT_SC];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[TOTAL-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    vx_r[0] <= in_vec_x;
    vy_r[0] <= in_vec_y;
    vz_r[0] <= in_vec_z;
    for (int k = 1; k <= LAT_SC; k++) begin
      vx_r[k] <= vx_r[k-1];
      vy_r[k] <= vy_r[k-1];
      vz_r[k] <= vz_r[k-1];
    end
  end

  // trig products, rounded to Q2.30
  function automatic logic signed [CW-1:0] mul_trig(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    p = (a * b) + (2*CW)'(64'sd536870912);
    return CW'(p >>> 30);
  endfunction

  logic signed [CW-1:0] ce_x_r, ce_y_r;
  logic signed [CW-1:0] cn_x_r, cn_y_r, cn_z_r;
  logic signed [CW-1:0] cu_x_r, cu_y_r, cu_z_r;

  always_ff @(posedge clk) begin
    ce_x_r <= -slon;
    ce_y_r <= clon;
    cn_x_r <= -mul_trig(slat, clon);
    cn_y_r <= -mul_trig(slat, slon);
    cn_z_r <= clat;
    cu_x_r <= mul_trig(clat, clon);
    cu_y_r <= mul_trig(clat, slon);
    cu_z_r <= slat;
  end

  function automatic logic signed [PW-1:0] mul_comp(input logic signed [31:0] v,
                                                    input logic signed [CW-1:0] c);
    logic signed [CW+31:0] p;
    p = v * c;
    return PW'(p >>> 14);
  endfunction

  logic signed [PW-1:0] pe_x_r, pe_y_r;
  logic signed [PW-1:0] pn_x_r, pn_y_r, pn_z_r;
  logic signed [PW-1:0] pu_x_r, pu_y_r, pu_z_r;

  always_ff @(posedge clk) begin
    pe_x_r <= mul_comp(vx_r[LAT_SC], ce_x_r);
    pe_y_r <= mul_comp(vy_r[LAT_SC], ce_y_r);
    pn_x_r <= mul_comp(vx_r[LAT_SC], cn_x_r);
    pn_y_r <= mul_comp(vy_r[LAT_SC], cn_y_r);
    pn_z_r <= mul_comp(vz_r[LAT_SC], cn_z_r);
    pu_x_r <= mul_comp(vx_r[LAT_SC], cu_x_r);
    pu_y_r <= mul_comp(vy_r[LAT_SC], cu_y_r);
    pu_z_r <= mul_comp(vz_r[LAT_SC], cu_z_r);
  end

  function automatic logic signed [SW-1:0] sum_round(input logic signed [PW-1:0] a,
                                                     input logic signed [PW-1:0] b,
                                                     input logic signed [PW-1:0] c);
    logic signed [PW+1:0] s;
    s = (PW+2)'(a) + (PW+2)'(b) + (PW+2)'(c) + (PW+2)'(32768);
    return SW'(s >>> 16);
  endfunction

  logic signed [SW-1:0] se_r, sn_r, su_r;

  always_ff @(posedge clk) begin
    se_r <= sum_round(pe_x_r, pe_y_r, '0);
    sn_r <= sum_round(pn_x_r, pn_y_r, pn_z_r);
    su_r <= sum_round(pu_x_r, pu_y_r, pu_z_r);
  end

  function automatic logic signed [31:0] clamp32(input logic signed [SW-1:0] v);
    logic signed [31:0] r;
    if (v > MAX32)      r = 32'sh7fffffff;
    else if (v < MIN32) r = 32'sh80000000;
    else                r = v[31:0];
    return r;
  endfunction

  function automatic logic ovf(input logic signed [SW-1:0] v);
    return (v > MAX32) || (v < MIN32);
  endfunction

  always_ff @(posedge clk) begin
    out_east_out  <= clamp32(se_r);
    out_north_out <= clamp32(sn_r);
    out_up_out    <= clamp32(su_r);
    out_saturated <= ovf(se_r) | ovf(sn_r) | ovf(su_r);
  end

  assign out_valid = vld_r[TOTAL-1];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##TOTAL out_valid)
    else $error("item did not emerge after pipeline latency");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_east_out == 32'sh7fffffff || out_east_out == 32'sh80000000 ||
       out_north_out == 32'sh7fffffff || out_north_out == 32'sh80000000 ||
       out_up_out == 32'sh7fffffff || out_up_out == 32'sh80000000))
    else $error("saturation flag without clipped component");

endmodule
`default_nettype wire
